// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the sector filter RTL.
// ----------------------------------------------------------------------------
// Each expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SMAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SMAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/smaf_pkg.sv =====
// ----------------------------------------------------------------------------
// smaf_pkg
// Shared types, constants and the reciprocal table of the sector filter.
// ----------------------------------------------------------------------------
package smaf_pkg;

  localparam int SECTOR_COUNT   = 8;
  localparam int SEC_W          = 3;
  localparam int ANGLE_FULL_Q6  = 23040;
  localparam int SECTOR_SPAN_Q6 = 2880;
  localparam logic [15:0] STALE_RESET = 16'd500;

  // Reciprocal scaling: floor(2^RECIP_SHIFT / c) for counts 1..16
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;

  typedef struct packed {
    logic               sample_valid;
    logic signed [15:0] angle_q6;
    logic [15:0]        sample_distance;
    logic [31:0]        now_ms;
    logic [18:0]        fallback_min_distance;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  sector_index;
    logic        sector_has_value;
    logic [2:0]  sector_sample_count;
    logic [15:0] sector_average;
    logic [18:0] min_distance;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [SEC_W-1:0] sector;
  } store_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_MEAN,
    ST_EMIT
  } state_t;

  function automatic logic [RECIP_W-1:0] recip_of(input logic [4:0] c);
    logic [RECIP_W-1:0] r;
    case (c)
      5'd1:    r = 21'd1048576;
      5'd2:    r = 21'd524288;
      5'd3:    r = 21'd349525;
      5'd4:    r = 21'd262144;
      5'd5:    r = 21'd209715;
      5'd6:    r = 21'd174762;
      5'd7:    r = 21'd149796;
      5'd8:    r = 21'd131072;
      5'd9:    r = 21'd116508;
      5'd10:   r = 21'd104857;
      5'd11:   r = 21'd95325;
      5'd12:   r = 21'd87381;
      5'd13:   r = 21'd80659;
      5'd14:   r = 21'd74898;
      5'd15:   r = 21'd69905;
      5'd16:   r = 21'd65536;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/smaf_div.sv =====
// ----------------------------------------------------------------------------
// smaf_div
// Shared mean unit: sum / count by reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module smaf_div import smaf_pkg::*; #(
  parameter int SUM_W = 18,
  parameter int CNT_W = 3
) (
  input  logic             clk,
  input  logic             go,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [CNT_W-1:0] cnt_i,
  output logic [15:0]      mean_o
);

  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int DW     = 16 + CNT_W + 1;

  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [15:0]   q0;
  logic [DW-1:0] back;
  logic [DW-1:0] rem;

  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= PROD_W'(sum_i) * PROD_W'(recip_of(5'(cnt_i)));
      sum_r  <= sum_i;
      cnt_r  <= cnt_i;
    end
  end

  // Estimate is the true quotient or one below it
  always_comb begin
    q0     = prod_r[RECIP_SHIFT +: 16];
    back   = DW'(q0) * DW'(cnt_r);
    rem    = DW'(sum_r) - back;
    mean_o = (rem >= DW'(cnt_r)) ? q0 + 16'd1 : q0;
  end

endmodule

// ===== hw/rtl/smaf_store.sv =====
// ----------------------------------------------------------------------------
// smaf_store
// Per-sector sample rings with running sum, count, write slot and timestamp.
// ----------------------------------------------------------------------------
module smaf_store import smaf_pkg::*; #(
  parameter int WINDOW_DEPTH = 4,
  parameter int SUM_W        = 18,
  parameter int CNT_W        = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  store_cmd_t       cmd_i,
  input  logic [15:0]      dist_i,
  input  logic [31:0]      now_i,
  input  logic [SEC_W-1:0] scan_sector_i,
  output logic [SUM_W-1:0] scan_sum_o,
  output logic [CNT_W-1:0] scan_cnt_o,
  output logic [31:0]      scan_time_o
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int MEM_D  = SECTOR_COUNT * WINDOW_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);

  logic [15:0]       mem [MEM_D];
  logic [15:0]       old_r;
  logic [SUM_W-1:0]  sum_r  [SECTOR_COUNT];
  logic [CNT_W-1:0]  cnt_r  [SECTOR_COUNT];
  logic [SLOT_W-1:0] slot_r [SECTOR_COUNT];
  logic [31:0]       time_r [SECTOR_COUNT];

  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] addr;
  logic              full;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [SLOT_W-1:0] slot_nxt;

  always_comb begin
    slot     = slot_r[cmd_i.sector];
    addr     = ADDR_W'(32'(cmd_i.sector) * WINDOW_DEPTH + 32'(slot));
    full     = cnt_r[cmd_i.sector] == CNT_W'(WINDOW_DEPTH);
    // Full ring: drop the oldest word from the sum
    sum_nxt  = full ? sum_r[cmd_i.sector] - SUM_W'(old_r) + SUM_W'(dist_i)
                    : sum_r[cmd_i.sector] + SUM_W'(dist_i);
    cnt_nxt  = full ? cnt_r[cmd_i.sector] : cnt_r[cmd_i.sector] + CNT_W'(1);
    slot_nxt = (slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
  end

  // Oldest entry is read on every push but only used once the ring is full, so it has always been written
  always_ff @(posedge clk) begin
    if (cmd_i.rd) begin
      old_r <= mem[addr];
    end
    if (cmd_i.wr) begin
      mem[addr] <= dist_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SECTOR_COUNT; s++) begin
        sum_r[s]  <= '0;
        cnt_r[s]  <= '0;
        slot_r[s] <= '0;
        time_r[s] <= '0;
      end
    end else if (cmd_i.wr) begin
      sum_r[cmd_i.sector]  <= sum_nxt;
      cnt_r[cmd_i.sector]  <= cnt_nxt;
      slot_r[cmd_i.sector] <= slot_nxt;
      time_r[cmd_i.sector] <= now_i;
    end
  end

  assign scan_sum_o  = sum_r[scan_sector_i];
  assign scan_cnt_o  = cnt_r[scan_sector_i];
  assign scan_time_o = time_r[scan_sector_i];

endmodule

// ===== hw/rtl/sector_moving_average_filter.sv =====
// ----------------------------------------------------------------------------
// sector_moving_average_filter
// Per-sector moving average of range samples with a staleness timeout.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one sample word; it is
// taken when in_valid is high and in_stall low. in_stall is high from the
// accept until the eighth result has been loaded into the output register.
// Each input word yields eight result words on out_valid/out_stall/out_data,
// sector 0 first; the eighth has last set and carries the minimum distance.
// A pushing sample first passes through the ring update (read of the
// oldest entry, then write); then each sector in turn passes through
// the shared mean unit (reciprocal multiply, then correction) and its
// result is loaded into the output register. No new item is accepted
// before the eighth result is loaded. A stalled result holds in the
// output register and the sequencer waits for it before loading the
// next one.
// cfg_we/cfg_wdata write the stale limit in milliseconds; write it only
// while no item is in flight.
// Reset (rst_n low at a clock edge) empties every sector ring, clears
// timestamps to zero and sets the stale limit to 500 ms.
// ----------------------------------------------------------------------------
module sector_moving_average_filter import smaf_pkg::*; #(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = $clog2(WINDOW_DEPTH * 65535 + 1);

  state_t           state_r, state_nxt;
  in_word_t         in_r;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic             any_r, any_nxt;
  logic [15:0]      best_r, best_nxt;
  logic             has_r;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      limit_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  store_cmd_t       cmd;
  logic [SUM_W-1:0] scan_sum;
  logic [CNT_W-1:0] scan_cnt;
  logic [31:0]      scan_time;
  logic [15:0]      mean;
  logic             div_go;
  logic             has_now;
  logic [SEC_W-1:0] push_sec;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Sector of the held sample: wrap negative angles once, then threshold
  always_comb begin
    logic signed [16:0] a;
    logic [SEC_W-1:0]   n;
    a = 17'(in_r.angle_q6);
    n = '0;
    if (a < 0) begin
      a = a + 17'(ANGLE_FULL_Q6);
    end
    if (a >= 0) begin
      for (int k = 1; k < SECTOR_COUNT; k++) begin
        if (a >= 17'(k * SECTOR_SPAN_Q6)) begin
          n = n + SEC_W'(1);
        end
      end
    end
    push_sec = n;
  end

  smaf_store #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (cmd),
    .dist_i       (in_r.sample_distance),
    .now_i        (in_r.now_ms),
    .scan_sector_i(sec_r),
    .scan_sum_o   (scan_sum),
    .scan_cnt_o   (scan_cnt),
    .scan_time_o  (scan_time)
  );

  smaf_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk   (clk),
    .go    (div_go),
    .sum_i (scan_sum),
    .cnt_i (scan_cnt),
    .mean_o(mean)
  );

  assign has_now = (scan_cnt != '0) &&
                   ((in_r.now_ms - scan_time) <= 32'(limit_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sec_r       <= '0;
      any_r       <= 1'b0;
      best_r      <= '0;
      limit_r     <= STALE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      any_r       <= any_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (div_go) begin
      has_r <= has_now;
      cnt_r <= scan_cnt;
    end
    out_r <= out_nxt;
  end

  always_comb begin
    logic [15:0] avg;
    logic        last_one;
    state_nxt     = state_r;
    sec_nxt       = sec_r;
    any_nxt       = any_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    cmd           = '{rd: 1'b0, wr: 1'b0, sector: push_sec};
    div_go        = 1'b0;
    avg           = has_r ? mean : 16'd0;
    last_one      = (sec_r == SEC_W'(SECTOR_COUNT - 1));

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sec_nxt = '0;
          any_nxt = 1'b0;
          if (in_data.sample_valid && (in_data.sample_distance != 16'd0)) begin
            state_nxt = ST_PUSH_RD;
          end else begin
            state_nxt = ST_MEAN;
          end
        end
      end
      ST_PUSH_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_PUSH_WR;
      end
      ST_PUSH_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        div_go    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (has_r && (!any_r || avg < best_r)) begin
            best_nxt = avg;
          end
          any_nxt = any_r || has_r;
          out_nxt.sector_index        = sec_r;
          out_nxt.sector_has_value    = has_r;
          out_nxt.sector_sample_count = has_r ? 3'(cnt_r) : 3'd0;
          out_nxt.sector_average      = avg;
          out_nxt.last                = last_one;
          if (last_one) begin
            out_nxt.min_distance = any_nxt ? 19'(best_nxt)
                                           : in_r.fallback_min_distance;
            state_nxt = ST_IDLE;
          end else begin
            out_nxt.min_distance = '0;
            sec_nxt   = sec_r + SEC_W'(1);
            state_nxt = ST_MEAN;
          end
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SMAF_ASSERT_NOW(a_last_is_top_sector, out_valid && out_data.last,
    out_data.sector_index == 3'(SECTOR_COUNT - 1), "last word not on the top sector")
  `SMAF_ASSERT_NOW(a_min_only_on_last, out_valid && !out_data.last,
    out_data.min_distance == 19'd0, "minimum set on a word other than the last")
  `SMAF_ASSERT_NOW(a_empty_reads_zero, out_valid && !out_data.sector_has_value,
    out_data.sector_sample_count == 3'd0 && out_data.sector_average == 16'd0,
    "sector without value carries a count or mean")
  `SMAF_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != ST_IDLE,
    "sequencer stayed idle after an accepted word")

endmodule

// ===== test/tb_sector_moving_average_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_moving_average_filter
// Self-checking bench for the per-sector moving average filter.
// A short table of directed samples is followed by random samples in four
// stale-limit phases. Every accepted sample is run through a local model of
// the sector rings, and each result word is compared field by field.
// ----------------------------------------------------------------------------
module tb_sector_moving_average_filter import smaf_pkg::*; ();

  localparam int RING_DEPTH = 4;
  localparam int PHASE_ITEMS = 50;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t last_word;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // local copy of the sector rings
  logic [15:0] ring_entry [SECTOR_COUNT][RING_DEPTH];
  logic [17:0] ring_sum [SECTOR_COUNT];
  logic [2:0]  ring_fill [SECTOR_COUNT];
  logic [1:0]  ring_slot [SECTOR_COUNT];
  logic [31:0] sector_stamp [SECTOR_COUNT];
  logic [15:0] stale_limit;

  out_word_t   pending_sector_words [$];
  stim_row_t   directed_rows [$];
  logic [31:0] clock_ms = '0;
  int          boundary_angles [8] = '{-23040, 23039, -1, 0, 2879, 2880, 20159, 20160};
  int          mismatch_count = 0;
  int          samples_sent = 0;
  int          words_checked = 0;
  int          long_hold_req = 0;
  bit          no_idle = 1'b0;

  sector_moving_average_filter #(.WINDOW_DEPTH(RING_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [2:0] sector_of(input logic signed [15:0] ang);
    int a;
    a = int'(ang);
    if (a < 0) a += ANGLE_FULL_Q6;
    if (a < 0) return 3'd0;   // still negative after one wrap: saturate low
    a = a / SECTOR_SPAN_Q6;
    if (a >= SECTOR_COUNT) a = SECTOR_COUNT - 1;
    return a[2:0];
  endfunction

  function automatic void predict_sector_words(input in_word_t w);
    logic [2:0]  sec;
    logic [18:0] best;
    logic [31:0] age;
    logic [17:0] mean;
    bit          any_value;
    bit          has;
    out_word_t   r;
    best = '0;
    any_value = 1'b0;
    if (w.sample_valid && w.sample_distance != 16'd0) begin
      sec = sector_of(w.angle_q6);
      // full ring: the oldest entry leaves the sum
      if (ring_fill[sec] < RING_DEPTH) ring_fill[sec] = ring_fill[sec] + 3'd1;
      else ring_sum[sec] = ring_sum[sec] - 18'(ring_entry[sec][ring_slot[sec]]);
      ring_entry[sec][ring_slot[sec]] = w.sample_distance;
      ring_sum[sec] = ring_sum[sec] + 18'(w.sample_distance);
      ring_slot[sec] = ring_slot[sec] + 2'd1;
      sector_stamp[sec] = w.now_ms;
    end
    for (int s = 0; s < SECTOR_COUNT; s++) begin
      age = w.now_ms - sector_stamp[s];
      has = ring_fill[s] != 3'd0 && age <= {16'd0, stale_limit};
      mean = has ? ring_sum[s] / 18'(ring_fill[s]) : 18'd0;
      if (has && (!any_value || 19'(mean) < best)) best = 19'(mean);
      if (has) any_value = 1'b1;
      r.sector_index = s[2:0];
      r.sector_has_value = has;
      r.sector_sample_count = has ? ring_fill[s] : 3'd0;
      r.sector_average = mean[15:0];
      r.min_distance = '0;
      r.last = 1'b0;
      if (s == SECTOR_COUNT - 1) begin
        r.min_distance = any_value ? best : w.fallback_min_distance;
        r.last = 1'b1;
      end
      pending_sector_words.push_back(r);
    end
  endfunction

  function automatic stim_row_t make_row(input bit v, input int ang, input int range_q2,
                                         input logic [31:0] ts, input int fb,
                                         input bit typed, input out_word_t last_word);
    stim_row_t row;
    row.word.sample_valid = v;
    row.word.angle_q6 = ang[15:0];
    row.word.sample_distance = range_q2[15:0];
    row.word.now_ms = ts;
    row.word.fallback_min_distance = fb[18:0];
    row.typed = typed;
    row.last_word = last_word;
    return row;
  endfunction

  // eighth word of a run, given field by field from the expected ring contents
  function automatic out_word_t closing_word(input bit has, input int cnt, input int avg,
                                             input int min_dist);
    out_word_t r;
    r.sector_index = 3'd7;
    r.sector_has_value = has;
    r.sector_sample_count = cnt[2:0];
    r.sector_average = avg[15:0];
    r.min_distance = min_dist[18:0];
    r.last = 1'b1;
    return r;
  endfunction

  function automatic in_word_t random_sample_word();
    in_word_t w;
    int       pick;
    w.sample_valid = $urandom_range(0, 9) != 0;
    pick = $urandom_range(0, 9);
    if (pick < 7) w.angle_q6 = 16'(int'($urandom_range(0, 46079)) - ANGLE_FULL_Q6);
    else if (pick == 7) w.angle_q6 = 16'(boundary_angles[$urandom_range(0, 7)]);
    else w.angle_q6 = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) w.sample_distance = '0;
    else if (pick == 1) w.sample_distance = 16'hFFFF;
    else if (pick < 4) w.sample_distance = 16'($urandom_range(1, 50));
    else w.sample_distance = 16'($urandom);
    // advance time mostly in small steps so that sectors stay fresh
    pick = $urandom_range(0, 19);
    if (pick == 0) clock_ms = clock_ms + $urandom;
    else if (pick < 6) clock_ms = clock_ms;
    else clock_ms = clock_ms + $urandom_range(1, 200);
    w.now_ms = clock_ms;
    if ($urandom_range(0, 9) == 0) w.fallback_min_distance = 19'($urandom);
    else w.fallback_min_distance = 19'($urandom_range(0, 399996));
    return w;
  endfunction

  task automatic report_mismatch(input string field, input int got_val, input int want_val);
    $display("MISMATCH %s: got %0d, want %0d (result %0d)", field, got_val, want_val,
             words_checked);
    mismatch_count++;
  endtask

  // enter and leave on a falling edge
  task automatic send_sample(input in_word_t w, input bit typed, input out_word_t last_word);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predict_sector_words(w);
    if (typed) pending_sector_words[pending_sector_words.size() - 1] = last_word;
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic write_stale_limit(input logic [15:0] limit);
    in_valid <= 1'b0;
    wait (pending_sector_words.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    stale_limit = limit;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sector_words.size() == 0) begin
        report_mismatch("unexpected result word", int'(out_data.sector_index), -1);
      end else begin
        want = pending_sector_words.pop_front();
        if (out_data.sector_index != want.sector_index)
          report_mismatch("sector_index", int'(out_data.sector_index),
                          int'(want.sector_index));
        if (out_data.sector_has_value != want.sector_has_value)
          report_mismatch("sector_has_value", int'(out_data.sector_has_value),
                          int'(want.sector_has_value));
        if (out_data.sector_sample_count != want.sector_sample_count)
          report_mismatch("sector_sample_count", int'(out_data.sector_sample_count),
                          int'(want.sector_sample_count));
        if (out_data.sector_average != want.sector_average)
          report_mismatch("sector_average", int'(out_data.sector_average),
                          int'(want.sector_average));
        if (out_data.min_distance != want.min_distance)
          report_mismatch("min_distance", int'(out_data.min_distance),
                          int'(want.min_distance));
        if (out_data.last != want.last)
          report_mismatch("last", int'(out_data.last), int'(want.last));
        words_checked++;
      end
    end
  end

  // result side: random stall before each word, plus one long hold-off on request
  initial begin : drain_results
    int hold;
    @(negedge clk);
    forever begin
      if (long_hold_req > 0) begin
        hold = long_hold_req;
        long_hold_req = 0;
      end else if (no_idle) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 6);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("sector_moving_average_filter test failed");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] phase_limits [4];
    for (int s = 0; s < SECTOR_COUNT; s++) begin
      for (int k = 0; k < RING_DEPTH; k++) ring_entry[s][k] = '0;
      ring_sum[s] = '0;
      ring_fill[s] = '0;
      ring_slot[s] = '0;
      sector_stamp[s] = '0;
    end
    stale_limit = STALE_RESET;

    // empty rings, fallback passed through, extremes of the fields
    directed_rows.push_back(make_row(0, 0, 0, 32'd0, 12345, 1, closing_word(0, 0, 0, 12345)));
    directed_rows.push_back(make_row(0, 100, 500, 32'd10, 19'h7FFFF, 1,
                                     closing_word(0, 0, 0, 19'h7FFFF)));
    directed_rows.push_back(make_row(1, 100, 0, 32'd20, 777, 1, closing_word(0, 0, 0, 777)));
    directed_rows.push_back(make_row(1, 23039, 65535, 32'd30, 0, 1,
                                     closing_word(1, 1, 65535, 65535)));
    directed_rows.push_back(make_row(1, 0, 1, 32'd40, 0, 1, closing_word(1, 1, 65535, 1)));
    // negative angles, angle below a full turn, angles at or past the top
    directed_rows.push_back(make_row(1, -1, 3, 32'd50, 0, 0, '0));
    directed_rows.push_back(make_row(1, -23040, 9, 32'd60, 0, 0, '0));
    directed_rows.push_back(make_row(1, -32768, 20, 32'd70, 0, 0, '0));
    directed_rows.push_back(make_row(1, 32767, 100, 32'd80, 0, 0, '0));
    directed_rows.push_back(make_row(1, 23040, 7, 32'd90, 0, 0, '0));
    directed_rows.push_back(make_row(1, 22000, 50, 32'd100, 0, 0, '0));
    // overfill one ring
    directed_rows.push_back(make_row(1, 8640, 40000, 32'd110, 0, 0, '0));
    directed_rows.push_back(make_row(1, 9000, 65535, 32'd120, 0, 0, '0));
    directed_rows.push_back(make_row(1, 10000, 1, 32'd130, 0, 0, '0));
    directed_rows.push_back(make_row(1, 11519, 2, 32'd140, 0, 0, '0));
    directed_rows.push_back(make_row(1, 8640, 30000, 32'd150, 0, 0, '0));
    directed_rows.push_back(make_row(1, 2879, 5, 32'd160, 0, 0, '0));
    directed_rows.push_back(make_row(1, 2880, 6, 32'd170, 0, 0, '0));
    // age right at and just past the limit
    directed_rows.push_back(make_row(0, 0, 0, 32'd650, 0, 0, '0));
    directed_rows.push_back(make_row(0, 0, 0, 32'd661, 0, 0, '0));
    directed_rows.push_back(make_row(0, 0, 0, 32'hFFFFFFFF, 1, 1, closing_word(0, 0, 0, 1)));
    // timestamp wrap keeps a sector fresh
    directed_rows.push_back(make_row(1, 5000, 1234, 32'hFFFFFFF0, 0, 0, '0));
    directed_rows.push_back(make_row(0, 0, 0, 32'h00000010, 3, 0, '0));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].last_word);

    phase_limits[0] = 16'd0;
    phase_limits[1] = 16'hFFFF;
    phase_limits[2] = 16'($urandom_range(1, 2000));
    phase_limits[3] = STALE_RESET;
    clock_ms = $urandom;
    for (int p = 0; p < 4; p++) begin
      write_stale_limit(phase_limits[p]);
      // hold the result side off long enough to back the input up
      if (p == 0) long_hold_req = 300;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        no_idle = (p == 1 && i < 40);
        send_sample(random_sample_word(), 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    in_valid <= 1'b0;
    wait (pending_sector_words.size() == 0);
    repeat (30) @(posedge clk);

    $display("Ran %0d samples (%0d result words) through stale limits 500, 0, 65535, %0d",
             samples_sent, words_checked, phase_limits[2]);
    $display("with ring overflow, angle wrap and clamp, timestamp wrap and a long hold-off");
    if (mismatch_count == 0) begin
      $display("sector_moving_average_filter test passed");
    end else begin
      $display("sector_moving_average_filter test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/smaf_pkg.sv
hw/rtl/smaf_div.sv
hw/rtl/smaf_store.sv
hw/rtl/sector_moving_average_filter.sv
test/tb_sector_moving_average_filter.sv
